>>> rtl/fk6_pkg.sv
// Package of shared types, constants and functions for the six-joint forward kinematics unit.
package fk6_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_BASE_HEIGHT = 3'd0;
	localparam logic [2:0] REG_SHOULDER_HEIGHT = 3'd1;
	localparam logic [2:0] REG_UPPER_ARM = 3'd2;
	localparam logic [2:0] REG_FOREARM_Z = 3'd3;
	localparam logic [2:0] REG_FOREARM_X = 3'd4;
	localparam logic [2:0] REG_WRIST_X = 3'd5;
	localparam logic [2:0] REG_TOOL_X = 3'd6;

	localparam int CfgWidth = 32;
	localparam int PosWidth = 35;
	localparam int RotOutWidth = 18;
	// Internal position width: wide enough for any chained sum before output.
	localparam int PosIntWidth = 40;

	// Rotation axes of the joints.
	typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

	// Link offsets held by the configuration registers.
	typedef struct packed {
		logic signed [CfgWidth-1:0] base_height;
		logic signed [CfgWidth-1:0] shoulder_height;
		logic signed [CfgWidth-1:0] upper_arm_length;
		logic signed [CfgWidth-1:0] forearm_z_offset;
		logic signed [CfgWidth-1:0] forearm_x_offset;
		logic signed [CfgWidth-1:0] wrist_x_offset;
		logic signed [CfgWidth-1:0] tool_x_offset;
	} links_t;

	// Reciprocals of the sine series divisors 156, 110, 72, 42, 20 and 6.
	// Each is the ceiling of 2^k / d with k = 31 + ceil(log2 d), which gives the
	// exact quotient for every dividend below 2^31.
	function automatic logic [31:0] sin_rcp(input int i);
		case (i)
			0: sin_rcp = 32'd3524075731;
			1: sin_rcp = 32'd2498890064;
			2: sin_rcp = 32'd3817748708;
			3: sin_rcp = 32'd3272356036;
			4: sin_rcp = 32'd3435973837;
			default: sin_rcp = 32'd2863311531;
		endcase
	endfunction

	function automatic int sin_shift(input int i);
		case (i)
			0: sin_shift = 39;
			1: sin_shift = 38;
			2: sin_shift = 38;
			3: sin_shift = 37;
			4: sin_shift = 36;
			default: sin_shift = 34;
		endcase
	endfunction

	// Reciprocals of the cosine series divisors 182, 132, 90, 56, 30, 12 and 2.
	function automatic logic [31:0] cos_rcp(input int i);
		case (i)
			0: cos_rcp = 32'd3020636341;
			1: cos_rcp = 32'd4164816772;
			2: cos_rcp = 32'd3054198967;
			3: cos_rcp = 32'd2454267027;
			4: cos_rcp = 32'd2290649225;
			5: cos_rcp = 32'd2863311531;
			default: cos_rcp = 32'd2147483648;
		endcase
	endfunction

	function automatic int cos_shift(input int i);
		case (i)
			0: cos_shift = 39;
			1: cos_shift = 39;
			2: cos_shift = 38;
			3: cos_shift = 37;
			4: cos_shift = 36;
			5: cos_shift = 35;
			default: cos_shift = 32;
		endcase
	endfunction

endpackage

>>> rtl/fk6_trig.sv
// Pipelined sine and cosine of one binary angle by a folded Horner series.
module fk6_trig #(
	parameter int ANGLE_WIDTH = 16,
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [ANGLE_WIDTH-1:0] angle,
	output logic out_valid,
	output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
	output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);
	import fk6_pkg::*;

	localparam int RW = ANGLE_WIDTH - 2;
	localparam int NSTEP = 7;
	localparam logic [31:0] HALF_PI_Q31 = 32'hC90FDAA2;
	localparam logic [32:0] ONE_Q31 = 33'h080000000;
	localparam int TW = TRIG_FRAC_BITS + 2;

	// Stage 1: fold into the first octant.
	logic [1:0] quad_s1;
	logic swap_s1;
	logic [RW:0] r_s1;
	logic v_s1;
	logic [RW-1:0] r_in;
	logic [RW:0] r_fold;
	assign r_in = angle[RW-1:0];
	always_comb begin
		if ({1'b0, r_in} > (RW+1)'(1 << (RW - 1)))
			r_fold = (RW+1)'(1 << RW) - {1'b0, r_in};
		else
			r_fold = {1'b0, r_in};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		quad_s1 <= angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
		swap_s1 <= ({1'b0, r_in} > (RW+1)'(1 << (RW - 1)));
		r_s1 <= r_fold;
	end

	// Stage 2: radians in Q31.
	logic [31:0] x_s2;
	logic [1:0] quad_s2;
	logic swap_s2;
	logic v_s2;
	logic [RW+32:0] xprod;
	assign xprod = {32'd0, r_s1} * {{(RW+1){1'b0}}, HALF_PI_Q31}
		+ (RW+33)'(1 << (RW - 1));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		x_s2 <= 32'(xprod >> RW);
		quad_s2 <= quad_s1;
		swap_s2 <= swap_s1;
	end

	// Stage 3: square of the radian value.
	logic [31:0] x_s3;
	logic [31:0] x2_s3;
	logic [1:0] quad_s3;
	logic swap_s3;
	logic v_s3;
	logic [63:0] sq;
	assign sq = 64'(x_s2) * 64'(x_s2) + 64'h40000000;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		x_s3 <= x_s2;
		x2_s3 <= 32'(sq >> 31);
		quad_s3 <= quad_s2;
		swap_s3 <= swap_s2;
	end

	// Horner steps: each term is a multiply stage then a reciprocal multiply stage
	// that divides by the series constant, if any. The dividend stays below 2^31.
	logic [32:0] ts_h [0:NSTEP];
	logic [32:0] tc_h [0:NSTEP];
	logic [31:0] hx [0:NSTEP];
	logic [31:0] hx2 [0:NSTEP];
	logic [1:0] hq [0:NSTEP];
	logic hsw [0:NSTEP];
	logic hv [0:NSTEP];
	assign ts_h[0] = ONE_Q31;
	assign tc_h[0] = ONE_Q31;
	assign hx[0] = x_s3;
	assign hx2[0] = x2_s3;
	assign hq[0] = quad_s3;
	assign hsw[0] = swap_s3;
	assign hv[0] = v_s3;

	for (genvar g = 0; g < NSTEP; g++) begin : g_horner
		logic [32:0] ps_s1;
		logic [32:0] pc_s1;
		logic [32:0] ts_s1;
		logic [31:0] x_m_s1;
		logic [31:0] x2_m_s1;
		logic [1:0] q_m_s1;
		logic sw_m_s1;
		logic v_m_s1;
		logic [32:0] ts_s2;
		logic [32:0] tc_s2;
		logic [31:0] x_d_s2;
		logic [31:0] x2_d_s2;
		logic [1:0] q_d_s2;
		logic sw_d_s2;
		logic v_d_s2;
		logic [65:0] ms;
		logic [65:0] mc;
		logic [63:0] qs;
		logic [63:0] qc;
		assign ms = 66'(hx2[g]) * 66'(ts_h[g]);
		assign mc = 66'(hx2[g]) * 66'(tc_h[g]);
		assign qs = 64'(ps_s1[31:0]) * 64'(sin_rcp(g));
		assign qc = 64'(pc_s1[31:0]) * 64'(cos_rcp(g));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_m_s1 <= 1'b0;
				v_d_s2 <= 1'b0;
			end else begin
				v_m_s1 <= hv[g];
				v_d_s2 <= v_m_s1;
			end
		end
		always_ff @(posedge clk) begin
			ps_s1 <= 33'(ms >> 31);
			pc_s1 <= 33'(mc >> 31);
			ts_s1 <= ts_h[g];
			x_m_s1 <= hx[g];
			x2_m_s1 <= hx2[g];
			q_m_s1 <= hq[g];
			sw_m_s1 <= hsw[g];
			if (g < NSTEP - 1)
				ts_s2 <= ONE_Q31 - 33'(qs >> sin_shift(g));
			else
				ts_s2 <= ts_s1;
			tc_s2 <= ONE_Q31 - 33'(qc >> cos_shift(g));
			x_d_s2 <= x_m_s1;
			x2_d_s2 <= x2_m_s1;
			q_d_s2 <= q_m_s1;
			sw_d_s2 <= sw_m_s1;
		end
		assign ts_h[g+1] = ts_s2;
		assign tc_h[g+1] = tc_s2;
		assign hx[g+1] = x_d_s2;
		assign hx2[g+1] = x2_d_s2;
		assign hq[g+1] = q_d_s2;
		assign hsw[g+1] = sw_d_s2;
		assign hv[g+1] = v_d_s2;
	end

	// Final multiply for the sine.
	logic [32:0] sn_s4;
	logic [32:0] cs_s4;
	logic [1:0] quad_s4;
	logic swap_s4;
	logic v_s4;
	logic [65:0] sp;
	assign sp = 66'(hx[NSTEP]) * 66'(ts_h[NSTEP]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= hv[NSTEP];
		end
	end
	always_ff @(posedge clk) begin
		sn_s4 <= 33'(sp >> 31);
		cs_s4 <= tc_h[NSTEP];
		quad_s4 <= hq[NSTEP];
		swap_s4 <= hsw[NSTEP];
	end

	// Round, unfold and apply the quadrant signs.
	logic [32:0] sa;
	logic [32:0] ca;
	logic signed [TW-1:0] s_r;
	logic signed [TW-1:0] c_r;
	always_comb begin
		sa = swap_s4 ? cs_s4 : sn_s4;
		ca = swap_s4 ? sn_s4 : cs_s4;
		s_r = TW'((sa + 33'(1 << (30 - TRIG_FRAC_BITS))) >> (31 - TRIG_FRAC_BITS));
		c_r = TW'((ca + 33'(1 << (30 - TRIG_FRAC_BITS))) >> (31 - TRIG_FRAC_BITS));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		case (quad_s4)
			2'd0: begin sin_val <= s_r; cos_val <= c_r; end
			2'd1: begin sin_val <= c_r; cos_val <= -s_r; end
			2'd2: begin sin_val <= -s_r; cos_val <= -c_r; end
			default: begin sin_val <= -c_r; cos_val <= s_r; end
		endcase
	end
endmodule

>>> rtl/fk6_chain.sv
// One chaining step: multiplies the running transform by one joint transform over two stages.
module fk6_chain #(
	parameter int TRIG_FRAC_BITS = 16,
	parameter fk6_pkg::axis_t AXIS = fk6_pkg::AXIS_Z
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [TRIG_FRAC_BITS+1:0] rot_in [0:8],
	input  logic signed [fk6_pkg::PosIntWidth-1:0] pos_in [0:2],
	input  logic signed [TRIG_FRAC_BITS+1:0] sin_val,
	input  logic signed [TRIG_FRAC_BITS+1:0] cos_val,
	input  logic signed [fk6_pkg::CfgWidth-1:0] off_x,
	input  logic signed [fk6_pkg::CfgWidth-1:0] off_z,
	output logic out_valid,
	output logic signed [TRIG_FRAC_BITS+1:0] rot_out [0:8],
	output logic signed [fk6_pkg::PosIntWidth-1:0] pos_out [0:2]
);
	import fk6_pkg::*;

	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int PW = TW + CfgWidth;
	localparam int SW = PW + 2;
	localparam int RPW = 2 * TW;
	localparam int RSW = RPW + 2;
	localparam logic signed [TW-1:0] UNIT = TW'(1 << TRIG_FRAC_BITS);

	// Rotation of this joint as a 3x3 matrix.
	logic signed [TW-1:0] h [0:8];
	always_comb begin
		for (int k = 0; k < 9; k++) h[k] = '0;
		case (AXIS)
			AXIS_Z: begin
				h[0] = cos_val; h[1] = -sin_val; h[3] = sin_val; h[4] = cos_val; h[8] = UNIT;
			end
			AXIS_Y: begin
				h[0] = cos_val; h[2] = sin_val; h[6] = -sin_val; h[8] = cos_val; h[4] = UNIT;
			end
			default: begin
				h[4] = cos_val; h[5] = -sin_val; h[7] = sin_val; h[8] = cos_val; h[0] = UNIT;
			end
		endcase
	end

	// Stage 1: all partial products.
	logic signed [RPW-1:0] rp_s1 [0:26];
	logic signed [PW-1:0] tpx_s1 [0:2];
	logic signed [PW-1:0] tpz_s1 [0:2];
	logic signed [PosIntWidth-1:0] pos_s1 [0:2];
	logic v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++)
					rp_s1[i*9+j*3+k] <= RPW'(rot_in[i*3+k]) * RPW'(h[k*3+j]);
			tpx_s1[i] <= PW'(rot_in[i*3]) * PW'(off_x);
			tpz_s1[i] <= PW'(rot_in[i*3+2]) * PW'(off_z);
			pos_s1[i] <= pos_in[i];
		end
	end

	// Stage 2: sums, rounding and the clamp.
	function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] v);
		logic [SW-1:0] m;
		m = v[SW-1] ? SW'(-v) : SW'(v);
		m = (m + SW'(1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
		rnd = v[SW-1] ? -$signed(m) : $signed(m);
	endfunction

	logic signed [SW-1:0] psum [0:2];
	logic signed [SW-1:0] rsum [0:8];
	logic signed [SW-1:0] rr [0:8];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			psum[i] = rnd(SW'(tpx_s1[i]) + SW'(tpz_s1[i]));
			for (int j = 0; j < 3; j++) begin
				rsum[i*3+j] = SW'(rp_s1[i*9+j*3]) + SW'(rp_s1[i*9+j*3+1])
					+ SW'(rp_s1[i*9+j*3+2]);
				rr[i*3+j] = rnd(rsum[i*3+j]);
				if (rr[i*3+j] > SW'(UNIT))
					rr[i*3+j] = SW'(UNIT);
				if (rr[i*3+j] < -SW'(UNIT))
					rr[i*3+j] = -SW'(UNIT);
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			pos_out[i] <= pos_s1[i] + PosIntWidth'(psum[i]);
		for (int k = 0; k < 9; k++)
			rot_out[k] <= TW'(rr[k]);
	end
endmodule

>>> rtl/six_joint_forward_kinematics_unit.sv
// Top level of the six-joint forward kinematics unit: registers, trig lanes and chain.
//
//  Channel   Ports                                  Transfer
//  config    cfg_we, cfg_index, cfg_data            cfg_we high at a clock edge
//  joints    start, busy, joint0..5_angle           start high while busy low
//  pose      done, rot_r*c*, pos_x/y/z              done high for one cycle
//
// One pose enters every clock cycle; busy is always low. A pose passes through the
// trig pipeline, then the chain of seven steps, then one output register.
// Reset clears the valid bits and the link registers.
// The receiver cannot stall, so the pipeline never stops.
module six_joint_forward_kinematics_unit #(
	parameter int ANGLE_WIDTH = 16,
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [fk6_pkg::CfgWidth-1:0] cfg_data,
	input  logic start,
	output logic busy,
	input  logic signed [ANGLE_WIDTH-1:0] joint0_angle,
	input  logic signed [ANGLE_WIDTH-1:0] joint1_angle,
	input  logic signed [ANGLE_WIDTH-1:0] joint2_angle,
	input  logic signed [ANGLE_WIDTH-1:0] joint3_angle,
	input  logic signed [ANGLE_WIDTH-1:0] joint4_angle,
	input  logic signed [ANGLE_WIDTH-1:0] joint5_angle,
	output logic done,
	output logic signed [fk6_pkg::RotOutWidth-1:0] rot_r0c0,
	output logic signed [fk6_pkg::RotOutWidth-1:0] rot_r0c1,
	output logic signed [fk6_pkg::RotOutWidth-1:0] rot_r0c2,
	output logic signed [fk6_pkg::RotOutWidth-1:0] rot_r1c0,
	output logic signed [fk6_pkg::RotOutWidth-1:0] rot_r1c1,
	output logic signed [fk6_pkg::RotOutWidth-1:0] rot_r1c2,
	output logic signed [fk6_pkg::RotOutWidth-1:0] rot_r2c0,
	output logic signed [fk6_pkg::RotOutWidth-1:0] rot_r2c1,
	output logic signed [fk6_pkg::RotOutWidth-1:0] rot_r2c2,
	output logic signed [fk6_pkg::PosWidth-1:0] pos_x,
	output logic signed [fk6_pkg::PosWidth-1:0] pos_y,
	output logic signed [fk6_pkg::PosWidth-1:0] pos_z
);
	import fk6_pkg::*;

	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int NJ = 6;
	localparam int CHAIN_LAT = 2;
	localparam logic signed [TW-1:0] UNIT = TW'(1 << TRIG_FRAC_BITS);

	assign busy = 1'b0;

	// Link registers.
	links_t links_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			links_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_HEIGHT: links_q.base_height <= cfg_data;
				REG_SHOULDER_HEIGHT: links_q.shoulder_height <= cfg_data;
				REG_UPPER_ARM: links_q.upper_arm_length <= cfg_data;
				REG_FOREARM_Z: links_q.forearm_z_offset <= cfg_data;
				REG_FOREARM_X: links_q.forearm_x_offset <= cfg_data;
				REG_WRIST_X: links_q.wrist_x_offset <= cfg_data;
				REG_TOOL_X: links_q.tool_x_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	// Six trig lanes in parallel.
	logic [ANGLE_WIDTH-1:0] ang [0:NJ-1];
	logic signed [TW-1:0] sv [0:NJ-1];
	logic signed [TW-1:0] cv [0:NJ-1];
	logic tv [0:NJ-1];
	logic in_fire;
	assign in_fire = start && !busy;
	assign ang[0] = joint0_angle;
	assign ang[1] = joint1_angle;
	assign ang[2] = joint2_angle;
	assign ang[3] = joint3_angle;
	assign ang[4] = joint4_angle;
	assign ang[5] = joint5_angle;
	for (genvar g = 0; g < NJ; g++) begin : g_trig
		fk6_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig (
			.clk(clk), .arst_n(arst_n), .in_valid(in_fire), .angle(ang[g]),
			.out_valid(tv[g]), .sin_val(sv[g]), .cos_val(cv[g])
		);
	end

	// Chain of seven steps; trig values of later joints are delayed to meet their step.
	logic signed [TW-1:0] rot_c [0:7][0:8];
	logic signed [PosIntWidth-1:0] pos_c [0:7][0:2];
	logic vc [0:7];
	always_comb begin
		for (int k = 0; k < 9; k++)
			rot_c[0][k] = (k == 0 || k == 4 || k == 8) ? UNIT : '0;
		for (int k = 0; k < 3; k++)
			pos_c[0][k] = '0;
	end
	assign vc[0] = tv[0];

	localparam axis_t AX [0:6] = '{AXIS_Z, AXIS_Y, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X, AXIS_Y};
	logic signed [CfgWidth-1:0] offx [0:6];
	logic signed [CfgWidth-1:0] offz [0:6];
	assign offx = '{'0, '0, '0, links_q.forearm_x_offset, links_q.wrist_x_offset,
		links_q.tool_x_offset, '0};
	assign offz = '{links_q.base_height, links_q.shoulder_height, links_q.upper_arm_length,
		links_q.forearm_z_offset, '0, '0, '0};

	for (genvar g = 0; g < 7; g++) begin : g_chain
		logic signed [TW-1:0] s_d;
		logic signed [TW-1:0] c_d;
		if (g == 6) begin : g_const
			assign s_d = UNIT;
			assign c_d = '0;
		end else if (g == 0) begin : g_first
			assign s_d = sv[0];
			assign c_d = cv[0];
		end else begin : g_delay
			localparam int D = g * CHAIN_LAT;
			logic signed [TW-1:0] sd_s [0:D-1];
			logic signed [TW-1:0] cd_s [0:D-1];
			always_ff @(posedge clk) begin
				sd_s[0] <= sv[g];
				cd_s[0] <= cv[g];
				for (int k = 1; k < D; k++) begin
					sd_s[k] <= sd_s[k-1];
					cd_s[k] <= cd_s[k-1];
				end
			end
			assign s_d = sd_s[D-1];
			assign c_d = cd_s[D-1];
		end
		fk6_chain #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .AXIS(AX[g])) u_chain (
			.clk(clk), .arst_n(arst_n), .in_valid(vc[g]),
			.rot_in(rot_c[g]), .pos_in(pos_c[g]),
			.sin_val(s_d), .cos_val(c_d), .off_x(offx[g]), .off_z(offz[g]),
			.out_valid(vc[g+1]), .rot_out(rot_c[g+1]), .pos_out(pos_c[g+1])
		);
	end

	// Output rounding of the rotation to 16 fraction bits, or widening when it has fewer.
	function automatic logic signed [RotOutWidth-1:0] rot_o(input logic signed [TW-1:0] v);
		logic [TW:0] m;
		if (TRIG_FRAC_BITS > 16) begin
			m = v[TW-1] ? (TW+1)'(-v) : (TW+1)'(v);
			m = (m + (TW+1)'(1 << (TRIG_FRAC_BITS - 17))) >> (TRIG_FRAC_BITS - 16);
			rot_o = v[TW-1] ? -RotOutWidth'(m) : RotOutWidth'(m);
		end else begin
			m = '0;
			rot_o = RotOutWidth'(v) <<< (16 - TRIG_FRAC_BITS);
		end
	endfunction

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vc[7];
		end
	end
	always_ff @(posedge clk) begin
		rot_r0c0 <= rot_o(rot_c[7][0]);
		rot_r0c1 <= rot_o(rot_c[7][1]);
		rot_r0c2 <= rot_o(rot_c[7][2]);
		rot_r1c0 <= rot_o(rot_c[7][3]);
		rot_r1c1 <= rot_o(rot_c[7][4]);
		rot_r1c2 <= rot_o(rot_c[7][5]);
		rot_r2c0 <= rot_o(rot_c[7][6]);
		rot_r2c1 <= rot_o(rot_c[7][7]);
		rot_r2c2 <= rot_o(rot_c[7][8]);
		pos_x <= PosWidth'(pos_c[7][0]);
		pos_y <= PosWidth'(pos_c[7][1]);
		pos_z <= PosWidth'(pos_c[7][2]);
	end

`ifndef SYNTHESIS
	// Trig lanes 0 and 5 stay in step.
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		tv[0] == tv[5]) else $error("trig lanes out of step");
	// A result follows the last chaining step in the next cycle.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		vc[7] |=> done) else $error("result lost at output");
	// No result without a chain step before it.
	a_nofake: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vc[7])) else $error("result invented");
`endif
endmodule
